### hdl/windkessel_bdf_pressure_step_assert.svh
// ---------------------------------------------------------------------------
// Windkessel BDF pressure step: assertion macros
// Concurrent checks clocked on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef WINDKESSEL_BDF_PRESSURE_STEP_ASSERT_SVH
`define WINDKESSEL_BDF_PRESSURE_STEP_ASSERT_SVH

// same-cycle implication
`define WBPS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps: same-cycle check failed");

// next-cycle implication
`define WBPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps: next-cycle check failed");

`endif

### hdl/wbps_pkg.sv
// ---------------------------------------------------------------------------
// wbps_pkg
// Shared types, codes and saturating Q32.32 helpers for the pressure step.
// ---------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

    localparam logic [7:0] DIV_STEPS = 8'd128;
    localparam logic [7:0] MUL_STEPS = 8'd4;
    localparam logic [7:0] ACC_STEPS = 8'd4;
    // 72-bit history sum divided by its denominator, one nibble per cycle
    localparam logic [7:0] K3_STEPS  = 8'd18;

    localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    localparam logic [2:0] CFG_RESISTANCE = 3'd0;
    localparam logic [2:0] CFG_COMPLIANCE = 3'd1;
    localparam logic [2:0] CFG_CHAR_IMP   = 3'd2;
    localparam logic [2:0] CFG_BDF_ORDER  = 3'd3;
    localparam logic [2:0] CFG_INIT_PRES  = 3'd4;
    localparam logic [2:0] CFG_INIT_FLOW  = 3'd5;

    localparam logic [1:0] ORD_1 = 2'd0;
    localparam logic [1:0] ORD_2 = 2'd1;
    localparam logic [1:0] ORD_3 = 2'd2;

    // micro-steps of one beat, in issue order
    typedef enum logic [3:0] {
        ST_ZR  = 4'd0,   // Z/R, then w = 1 + Z/R
        ST_QC  = 4'd1,   // Q/C
        ST_T1  = 4'd2,   // (Q/C)*w
        ST_ZDT = 4'd3,   // Z/dt
        ST_DQA = 4'd4,   // flow history combination
        ST_DQ  = 4'd5,   // combination / k
        ST_T2  = 4'd6,   // (Z/dt)*Dq
        ST_PGA = 4'd7,   // pressure history combination
        ST_PG  = 4'd8,   // combination / k
        ST_G   = 4'd9,   // Pg/dt, then numerator
        ST_ADT = 4'd10,  // a/dt
        ST_RC  = 4'd11,  // R*C
        ST_IRC = 4'd12,  // 1/(R*C), then denominator
        ST_P1  = 4'd13   // numerator / denominator
    } step_t;

    typedef struct packed {
        logic  start;
        step_t step;
        logic  load;
        logic  commit;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sts_t;

    function automatic logic [63:0] sat_from(input logic neg, input logic [127:0] m);
        logic [63:0] r;
        if (neg) begin
            if (m > {64'd0, S64_MIN})
                r = S64_MIN;
            else
                r = (~m[63:0]) + 64'd1;
        end
        else begin
            if (m > {64'd0, S64_MAX})
                r = S64_MAX;
            else
                r = m[63:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            r = a[63] ? S64_MIN : S64_MAX;
        return r;
    endfunction

    function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63])
            r = a[63] ? S64_MIN : S64_MAX;
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v) + 64'd1 : v;
    endfunction

    function automatic logic [1:0] order_sel(input logic [1:0] bdf);
        logic [1:0] o;
        unique case (bdf)
            2'd2:    o = ORD_2;
            2'd3:    o = ORD_3;
            default: o = ORD_1;
        endcase
        return o;
    endfunction

    function automatic logic [2:0] coef_div(input logic [1:0] o);
        logic [2:0] k;
        unique case (o)
            ORD_2:   k = 3'd2;
            ORD_3:   k = 3'd6;
            default: k = 3'd1;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] alpha_num(input logic [1:0] o);
        logic [3:0] a;
        unique case (o)
            ORD_2:   a = 4'd3;
            ORD_3:   a = 4'd11;
            default: a = 4'd1;
        endcase
        return a;
    endfunction

    function automatic logic signed [5:0] flow_coef(input logic [1:0] o, input logic [1:0] i);
        logic signed [5:0] c;
        c = 6'sd0;
        unique case (o)
            ORD_2: begin
                unique case (i)
                    2'd0:    c = 6'sd3;
                    2'd1:    c = -6'sd4;
                    2'd2:    c = 6'sd1;
                    default: c = 6'sd0;
                endcase
            end
            ORD_3: begin
                unique case (i)
                    2'd0:    c = 6'sd11;
                    2'd1:    c = -6'sd18;
                    2'd2:    c = 6'sd9;
                    default: c = -6'sd2;
                endcase
            end
            default: begin
                unique case (i)
                    2'd0:    c = 6'sd1;
                    2'd1:    c = -6'sd1;
                    default: c = 6'sd0;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [5:0] pres_coef(input logic [1:0] o, input logic [1:0] i);
        logic signed [5:0] c;
        c = 6'sd0;
        unique case (o)
            ORD_2: begin
                unique case (i)
                    2'd0:    c = -6'sd4;
                    2'd1:    c = 6'sd1;
                    default: c = 6'sd0;
                endcase
            end
            ORD_3: begin
                unique case (i)
                    2'd0:    c = -6'sd18;
                    2'd1:    c = 6'sd9;
                    2'd2:    c = -6'sd2;
                    default: c = 6'sd0;
                endcase
            end
            default: begin
                unique case (i)
                    2'd0:    c = -6'sd1;
                    default: c = 6'sd0;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/windkessel_bdf_pressure_step.sv
// ---------------------------------------------------------------------------
// windkessel_bdf_pressure_step
// Three-element Windkessel outlet pressure, one simulation time step per beat.
// ---------------------------------------------------------------------------
// Each input beat (flow_rate Q as Q32.32, time_step dt as unsigned Q31.32)
// yields one output beat new_pressure, computed by a backward difference of
// order 1, 2 or 3 over the stored pressure and flow history, which then
// shifts by one. A beat runs fourteen micro-steps, seven of which are 128-bit
// divisions through one shared divider that retires one quotient bit per
// cycle; the two divisions of a history sum by its constant denominator retire
// a nibble per cycle; the three multiplies run on a 32x32 partial-product
// unit and the two history combinations on a history accumulator. One beat
// is in flight at a time; a finished result sits in the output register, and
// the next input beat is taken while it waits. Configuration writes (cfg_we,
// cfg_index, cfg_data) are expected only while idle; writing initial_pressure
// or initial_flow reloads the whole pressure or flow history. All divisions
// and sums saturate.
// ---------------------------------------------------------------------------
`default_nettype none
`include "windkessel_bdf_pressure_step_assert.svh"

module windkessel_bdf_pressure_step (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input beat
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] flow_rate,
    input  wire logic [62:0] time_step,
    // output beat
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      new_pressure,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import wbps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: handshake and step order
    wbps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic, history and configuration registers
    wbps_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .flow_rate    (flow_rate),
        .time_step    (time_step),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .new_pressure (new_pressure)
    );

    // a step is only issued to an idle datapath
    `WBPS_ASSERT_IMPL(a_start_idle, cmd.start, !sts.busy)
    // an accepted beat blocks further input on the next cycle
    `WBPS_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
    // a committed result shows up as a valid output beat
    `WBPS_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid)

endmodule

`default_nettype wire

### hdl/wbps_dp.sv
// ---------------------------------------------------------------------------
// wbps_dp
// Datapath: config and history registers, a 1-bit/cycle 128-bit divider,
// a nibble/cycle divider by the history denominator, a 32x32 partial-product
// multiplier and a history accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module wbps_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire wbps_pkg::cmd_t  cmd,
    output wbps_pkg::sts_t       sts,
    input  wire logic [63:0]     flow_rate,
    input  wire logic [62:0]     time_step,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [63:0]     cfg_data,
    output logic [63:0]          new_pressure
);
    import wbps_pkg::*;

    // configuration
    logic [62:0] res_reg, cmp_reg, chr_reg;
    logic [1:0]  bdf_reg;

    // history
    logic [63:0] p0_reg, p1h_reg, p2h_reg;
    logic [63:0] f1_reg, f2_reg, f3_reg;

    // sequencing
    step_t       step_reg;
    logic [7:0]  cnt_reg;
    logic        fin_reg;

    // operands and units
    logic [63:0]  q_reg;
    logic [62:0]  dt_reg;
    logic         neg_reg, dz_reg, mz_reg;
    logic [127:0] nsh_reg;
    logic [126:0] rem_reg, dvs_reg;
    logic [63:0]  ma_reg, mb_reg;
    logic [127:0] prod_reg;
    logic signed [71:0] acc_reg;
    logic [1:0]   k3r_reg;

    // intermediate results
    logic [63:0]  w_reg, qc_reg, t1_reg, zdt_reg, dq_reg, t2_reg, pg_reg;
    logic [63:0]  num_reg, adt_reg, den_reg, p1_reg, out_reg;
    logic [125:0] rc_reg;

    logic [1:0]   ord;
    logic [2:0]   kdiv;
    logic [3:0]   anum;
    logic [65:0]  dt_k;
    logic [71:0]  acc_mag;
    logic [71:0]  k_mag;
    logic         k3_by3;
    logic         k3_step;

    logic         s_neg;
    logic [127:0] s_mag;
    logic [126:0] s_dvs;
    logic [63:0]  s_ma, s_mb;
    logic [7:0]   s_cnt;

    logic [127:0] r_sh, r_sub;
    logic         ge;
    logic [1:0]   ph;
    logic [31:0]  ah, bh;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [63:0]  a_val;
    logic signed [5:0]  a_coef;
    logic signed [69:0] a_term;
    logic [63:0]  div_res, mul_res;
    logic [5:0]   k3_v;
    logic [11:0]  k3_p;
    logic [3:0]   k3_q;
    logic [5:0]   k3_r6;

    assign ord     = order_sel(bdf_reg);
    assign kdiv    = coef_div(ord);
    assign anum    = alpha_num(ord);
    assign dt_k    = 66'(dt_reg) * 66'(kdiv);
    assign acc_mag = acc_reg[71] ? (~acc_reg) + 72'd1 : acc_reg;
    // k = 2 and k = 6 drop one bit first; k = 6 then divides by 3
    assign k_mag   = (ord == ORD_1) ? acc_mag : (acc_mag >> 1);
    assign k3_by3  = (ord == ORD_3);
    assign k3_step = (step_reg == ST_DQ) || (step_reg == ST_PG);

    // operand setup at the start of a step
    always_comb
    begin
        s_neg = 1'b0;
        s_mag = '0;
        s_dvs = '0;
        s_ma  = '0;
        s_mb  = '0;
        s_cnt = DIV_STEPS;
        unique case (cmd.step)
            ST_ZR:
            begin
                s_mag = {33'd0, chr_reg, 32'd0};
                s_dvs = {64'd0, res_reg};
            end
            ST_QC:
            begin
                s_neg = q_reg[63];
                s_mag = {32'd0, mag64(q_reg), 32'd0};
                s_dvs = {64'd0, cmp_reg};
            end
            ST_ZDT:
            begin
                s_mag = {33'd0, chr_reg, 32'd0};
                s_dvs = {64'd0, dt_reg};
            end
            ST_DQ, ST_PG:
            begin
                // dividend left-aligned, quotient nibbles shift in at the bottom
                s_neg = acc_reg[71];
                s_mag = {k_mag, 56'd0};
                s_dvs = {124'd0, kdiv};
                s_cnt = K3_STEPS;
            end
            ST_G:
            begin
                s_neg = pg_reg[63];
                s_mag = {32'd0, mag64(pg_reg), 32'd0};
                s_dvs = {64'd0, dt_reg};
            end
            ST_ADT:
            begin
                s_mag = {60'd0, anum, 64'd0};
                s_dvs = {61'd0, dt_k};
            end
            ST_IRC:
            begin
                s_mag = {31'd0, 1'b1, 96'd0};
                s_dvs = {1'b0, rc_reg};
            end
            ST_P1:
            begin
                s_neg = num_reg[63];
                s_mag = {32'd0, mag64(num_reg), 32'd0};
                s_dvs = {63'd0, den_reg};
            end
            ST_T1:
            begin
                s_neg = qc_reg[63];
                s_ma  = mag64(qc_reg);
                s_mb  = w_reg;
                s_cnt = MUL_STEPS;
            end
            ST_T2:
            begin
                s_neg = dq_reg[63];
                s_ma  = zdt_reg;
                s_mb  = mag64(dq_reg);
                s_cnt = MUL_STEPS;
            end
            ST_RC:
            begin
                s_ma  = {1'b0, res_reg};
                s_mb  = {1'b0, cmp_reg};
                s_cnt = MUL_STEPS;
            end
            ST_DQA, ST_PGA:
            begin
                s_cnt = ACC_STEPS;
            end
            default:
            begin
                s_cnt = DIV_STEPS;
            end
        endcase
    end

    // one iteration of each unit
    always_comb
    begin
        r_sh  = {rem_reg, nsh_reg[127]};
        ge    = r_sh >= {1'b0, dvs_reg};
        r_sub = ge ? r_sh - {1'b0, dvs_reg} : r_sh;

        // radix-16 digit of a divide by 3: v < 48, floor(v/3) = (v*43) >> 7
        k3_v  = {k3r_reg, nsh_reg[127:124]};
        k3_p  = 12'(k3_v) * 12'd43;
        k3_q  = k3_by3 ? k3_p[10:7] : k3_v[3:0];
        k3_r6 = k3_by3 ? (k3_v - 6'(k3_q) * 6'd3) : 6'd0;

        ph    = 2'(cnt_reg - 8'd1);
        ah    = ph[1] ? ma_reg[63:32] : ma_reg[31:0];
        bh    = ph[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp    = 64'(ah) * 64'(bh);
        unique case (ph)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase

        if (step_reg == ST_DQA)
        begin
            a_coef = flow_coef(ord, ph);
            unique case (ph)
                2'd0:    a_val = q_reg;
                2'd1:    a_val = f1_reg;
                2'd2:    a_val = f2_reg;
                default: a_val = f3_reg;
            endcase
        end
        else
        begin
            a_coef = pres_coef(ord, ph);
            unique case (ph)
                2'd0:    a_val = p0_reg;
                2'd1:    a_val = p1h_reg;
                2'd2:    a_val = p2h_reg;
                default: a_val = 64'd0;
            endcase
        end
        a_term = $signed(a_val) * a_coef;

        if (dz_reg)
            div_res = mz_reg ? 64'd0 : (neg_reg ? S64_MIN : S64_MAX);
        else
            div_res = sat_from(neg_reg, nsh_reg);
        mul_res = sat_from(neg_reg, {32'd0, prod_reg[127:32]});
    end

    assign sts.busy     = (cnt_reg != 8'd0) || fin_reg;
    assign sts.done     = fin_reg;
    assign new_pressure = out_reg;

    // control, configuration and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 8'd0;
            fin_reg  <= 1'b0;
            step_reg <= ST_ZR;
            res_reg  <= 63'(Q_ONE);
            cmp_reg  <= 63'(Q_ONE);
            chr_reg  <= '0;
            bdf_reg  <= 2'd1;
            p0_reg   <= '0;
            p1h_reg  <= '0;
            p2h_reg  <= '0;
            f1_reg   <= '0;
            f2_reg   <= '0;
            f3_reg   <= '0;
        end
        else
        begin
            fin_reg <= (cnt_reg == 8'd1);
            if (cmd.start)
            begin
                step_reg <= cmd.step;
                cnt_reg  <= s_cnt;
            end
            else if (cnt_reg != 8'd0)
            begin
                cnt_reg <= cnt_reg - 8'd1;
            end

            if (cmd.commit)
            begin
                p0_reg  <= p1_reg;
                p1h_reg <= p0_reg;
                p2h_reg <= p1h_reg;
                f1_reg  <= q_reg;
                f2_reg  <= f1_reg;
                f3_reg  <= f2_reg;
            end

            if (cfg_we)
            begin
                priority case (cfg_index)
                    CFG_RESISTANCE: res_reg <= cfg_data[62:0];
                    CFG_COMPLIANCE: cmp_reg <= cfg_data[62:0];
                    CFG_CHAR_IMP:   chr_reg <= cfg_data[62:0];
                    CFG_BDF_ORDER:  bdf_reg <= cfg_data[1:0];
                    CFG_INIT_PRES:
                    begin
                        p0_reg  <= cfg_data;
                        p1h_reg <= cfg_data;
                        p2h_reg <= cfg_data;
                    end
                    CFG_INIT_FLOW:
                    begin
                        f1_reg <= cfg_data;
                        f2_reg <= cfg_data;
                        f3_reg <= cfg_data;
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg  <= flow_rate;
            dt_reg <= time_step;
        end
        if (cmd.commit)
            out_reg <= p1_reg;

        if (cmd.start)
        begin
            neg_reg  <= s_neg;
            nsh_reg  <= s_mag;
            rem_reg  <= '0;
            dvs_reg  <= s_dvs;
            dz_reg   <= (s_dvs == '0);
            mz_reg   <= (s_mag == '0);
            ma_reg   <= s_ma;
            mb_reg   <= s_mb;
            prod_reg <= '0;
            acc_reg  <= '0;
            k3r_reg  <= 2'd0;
        end
        else if (cnt_reg != 8'd0)
        begin
            if (k3_step)
            begin
                nsh_reg <= {nsh_reg[123:0], k3_q};
                k3r_reg <= k3_r6[1:0];
            end
            else
            begin
                nsh_reg <= {nsh_reg[126:0], ge};
            end
            rem_reg  <= r_sub[126:0];
            prod_reg <= prod_reg + pp_sh;
            acc_reg  <= acc_reg + {{2{a_term[69]}}, a_term};
        end

        if (fin_reg)
        begin
            unique case (step_reg)
                ST_ZR:   w_reg   <= q_add(Q_ONE, div_res);
                ST_QC:   qc_reg  <= div_res;
                ST_T1:   t1_reg  <= mul_res;
                ST_ZDT:  zdt_reg <= div_res;
                ST_DQ:   dq_reg  <= div_res;
                ST_T2:   t2_reg  <= mul_res;
                ST_PG:   pg_reg  <= div_res;
                ST_G:    num_reg <= q_sub(q_add(t1_reg, t2_reg), div_res);
                ST_ADT:  adt_reg <= div_res;
                ST_RC:   rc_reg  <= prod_reg[125:0];
                ST_IRC:  den_reg <= q_add(adt_reg, div_res);
                ST_P1:   p1_reg  <= div_res;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/wbps_ctrl.sv
// ---------------------------------------------------------------------------
// wbps_ctrl
// Controller: input/output handshake and micro-step sequencing.
// ---------------------------------------------------------------------------
`default_nettype none

module wbps_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output wbps_pkg::cmd_t       cmd,
    input  wire wbps_pkg::sts_t  sts
);
    import wbps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept, out_free;

    assign accept     = in_valid && (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;

    assign cmd.load   = accept;
    assign cmd.start  = (state_reg == S_ISSUE);
    assign cmd.step   = step_reg;
    assign cmd.commit = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ISSUE;
                    step_next  = ST_ZR;
                end
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.done)
                begin
                    if (step_reg == ST_P1)
                        state_next = S_DONE;
                    else
                    begin
                        step_next  = step_t'(step_reg + 4'd1);
                        state_next = S_ISSUE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_ZR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### bench/testbench.sv
// ---------------------------------------------------------------------------
// Windkessel BDF pressure step testbench
// Drives time-step beats under a sweep of register settings and checks each
// new_pressure beat against an in-bench fixed-point predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import wbps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 40_000_000;
    localparam int unsigned DRAIN_WAIT  = 1000;
    localparam int unsigned PHASES      = 17;
    localparam int unsigned PHASE_BEATS = 103;
    localparam logic [62:0] MAX63       = 63'h7FFF_FFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] flow_rate;
    logic [62:0] time_step;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] new_pressure;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    windkessel_bdf_pressure_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .flow_rate    (flow_rate),
        .time_step    (time_step),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_pressure (new_pressure),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // -----------------------------------------------------------------------
    // Shadow of the registers and the history, kept in step with the block
    // -----------------------------------------------------------------------
    logic [62:0] res_r, comp_c, imp_z;
    logic [1:0]  ord_code;
    logic [63:0] pres_now, pres_b1, pres_b2;
    logic [63:0] flow_b1, flow_b2, flow_b3;

    logic [63:0] pending_pressure[$];
    int unsigned error_count;
    int unsigned cycle_count;
    bit          hold_req;

    // clamp a sign/magnitude pair to signed 64 bits
    function automatic logic [63:0] clamp_q(input bit neg, input logic [127:0] m);
        if (neg)
            return (m > {64'd0, S64_MIN}) ? S64_MIN : (~m[63:0]) + 64'd1;
        return (m > {64'd0, S64_MAX}) ? S64_MAX : m[63:0];
    endfunction

    function automatic logic [63:0] abs_q(input logic [63:0] v);
        return v[63] ? (~v) + 64'd1 : v;
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            r = a[63] ? S64_MIN : S64_MAX;
        return r;
    endfunction

    function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63])
            r = a[63] ? S64_MIN : S64_MAX;
        return r;
    endfunction

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
        return clamp_q(a[63] ^ b[63], p >> 32);
    endfunction

    // zero divisor: saturate toward the dividend's sign, zero over zero is zero
    function automatic logic [63:0] fx_div(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma, mb;
        ma = abs_q(a);
        mb = abs_q(b);
        if (mb == 64'd0)
            return (ma == 64'd0) ? 64'd0 : (a[63] ? S64_MIN : S64_MAX);
        return clamp_q(a[63] ^ b[63], {32'd0, ma, 32'd0} / {64'd0, mb});
    endfunction

    // exact signed sum of c[i]*v[i], truncated by k, then clamped
    function automatic logic [63:0] hist_sum(input int c0, input int c1, input int c2,
                                             input int c3, input logic [63:0] v0,
                                             input logic [63:0] v1, input logic [63:0] v2,
                                             input logic [63:0] v3, input int k);
        logic signed [127:0] acc;
        logic        [127:0] m;
        bit                  neg;
        acc = $signed({{64{v0[63]}}, v0}) * 128'(signed'(c0))
            + $signed({{64{v1[63]}}, v1}) * 128'(signed'(c1))
            + $signed({{64{v2[63]}}, v2}) * 128'(signed'(c2))
            + $signed({{64{v3[63]}}, v3}) * 128'(signed'(c3));
        neg = acc[127];
        m   = neg ? -acc : acc;
        return clamp_q(neg, m / 128'(k));
    endfunction

    // One time step: new pressure from Q, dt and history; history shifts.
    function automatic logic [63:0] bdf_pressure_next(input logic [63:0] q, input logic [62:0] dt);
        logic [63:0]  dt64, t1, t2, g, numer, adt, irc, denom, p1, dq, pg;
        logic [127:0] rc;
        int           k, an;
        dt64 = {1'b0, dt};
        case (ord_code)
            2'd2: begin
                k = 2; an = 3;
                dq = hist_sum(3, -4, 1, 0, q, flow_b1, flow_b2, flow_b3, k);
                pg = hist_sum(-4, 1, 0, 0, pres_now, pres_b1, pres_b2, 64'd0, k);
            end
            2'd3: begin
                k = 6; an = 11;
                dq = hist_sum(11, -18, 9, -2, q, flow_b1, flow_b2, flow_b3, k);
                pg = hist_sum(-18, 9, -2, 0, pres_now, pres_b1, pres_b2, 64'd0, k);
            end
            default: begin   // codes 0 and 1 both run first order
                k = 1; an = 1;
                dq = hist_sum(1, -1, 0, 0, q, flow_b1, flow_b2, flow_b3, k);
                pg = hist_sum(-1, 0, 0, 0, pres_now, pres_b1, pres_b2, 64'd0, k);
            end
        endcase
        t1 = fx_mul(fx_div(q, {1'b0, comp_c}),
                    add_sat(Q_ONE, fx_div({1'b0, imp_z}, {1'b0, res_r})));
        t2 = fx_mul(fx_div({1'b0, imp_z}, dt64), dq);
        g  = fx_div(pg, dt64);
        numer = sub_sat(add_sat(t1, t2), g);
        if (dt64 == 64'd0)
            adt = S64_MAX;
        else
            adt = clamp_q(1'b0, ({64'(an), 64'd0} / {64'd0, dt64}) / 128'(k));
        rc  = {65'd0, res_r} * {65'd0, comp_c};
        irc = (rc == 128'd0) ? S64_MAX : clamp_q(1'b0, (128'd1 << 96) / rc);
        denom = add_sat(adt, irc);
        p1 = fx_div(numer, denom);
        flow_b3 = flow_b2;
        flow_b2 = flow_b1;
        flow_b1 = q;
        pres_b2 = pres_b1;
        pres_b1 = pres_now;
        pres_now = p1;
        return p1;
    endfunction

    // -----------------------------------------------------------------------
    // Clock, reset, cycle limit
    // -----------------------------------------------------------------------
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout waiting for pressure beats", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Output checker: every accepted beat pops the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pressure.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, new_pressure);
                error_count++;
            end
            else
            begin
                want = pending_pressure.pop_front();
                if (new_pressure !== want)
                begin
                    $display("%0t: new_pressure mismatch, expected %h, actual %h",
                             $time, want, new_pressure);
                    error_count++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random stalls, mostly short, a few long; one long hold-off
    // on request so the block backs up and stalls its input.
    // -----------------------------------------------------------------------
    initial
    begin
        int unsigned r, len;
        bit          stl;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_stall <= 1'b1;
                repeat (6000) @(negedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                stl = 1'b0;
                len = $urandom_range(1, 40);
            end
            else if (r < 95)
            begin
                stl = 1'b1;
                len = $urandom_range(1, 4);
            end
            else
            begin
                stl = 1'b1;
                len = $urandom_range(50, 2000);
            end
            out_stall <= stl;
            repeat (len) @(negedge clk);
        end
    end

    // -----------------------------------------------------------------------
    // Sender side helpers
    // -----------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_RESISTANCE: res_r    = val[62:0];
            CFG_COMPLIANCE: comp_c   = val[62:0];
            CFG_CHAR_IMP:   imp_z    = val[62:0];
            CFG_BDF_ORDER:  ord_code = val[1:0];
            CFG_INIT_PRES:
            begin
                pres_now = val; pres_b1 = val; pres_b2 = val;
            end
            CFG_INIT_FLOW:
            begin
                flow_b1 = val; flow_b2 = val; flow_b3 = val;
            end
            default: ;   // indexes above the map are ignored
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // drive one beat; expectation recorded on acceptance, then a random gap
    task automatic send_beat(input logic [63:0] q, input logic [62:0] dt,
                             input bit typed, input logic [63:0] typed_val);
        logic [63:0] p;
        int unsigned r, gap;
        in_valid  <= 1'b1;
        flow_rate <= q;
        time_step <= dt;
        do
            @(posedge clk);
        while (in_stall);
        p = bdf_pressure_next(q, dt);
        pending_pressure.push_back(typed ? typed_val : p);
        @(negedge clk);
        r = $urandom_range(0, 99);
        gap = (r < 70) ? 0 : (r < 97) ? $urandom_range(1, 5) : $urandom_range(100, 3000);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // stop offering first, so the last beat is not taken a second time
    task automatic drain_all();
        in_valid <= 1'b0;
        while (pending_pressure.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [62:0] pick_coef();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return 63'd1;
        if (r == 1) return MAX63;
        if (r == 2) return {$urandom, $urandom};
        return {27'd0, 4'($urandom_range(0, 15)), 32'($urandom)} | 63'd1;
    endfunction

    function automatic logic [63:0] rand_q();
        return $signed({$urandom, $urandom}) >>> $urandom_range(0, 40);
    endfunction

    function automatic logic [62:0] rand_dt();
        logic [62:0] d;
        d = 63'({$urandom, $urandom}) >> $urandom_range(0, 62);
        return (d == 63'd0) ? 63'd1 : d;
    endfunction

    // -----------------------------------------------------------------------
    // Directed rows, run at the reset settings
    // -----------------------------------------------------------------------
    typedef struct {
        logic [63:0] q;
        logic [62:0] dt;
        bit          typed;
        logic [63:0] want;
    } step_row_t;

    step_row_t rows[] = '{
        // zero flow on zero history stays at zero pressure
        '{64'd0,      63'd1,  1'b1, 64'd0},
        '{64'd0,      MAX63,  1'b1, 64'd0},
        '{64'd0,      63'(Q_ONE), 1'b1, 64'd0},
        // flow extremes against the shortest, unit and longest step
        '{S64_MAX,    63'd1,  1'b0, 64'd0},
        '{S64_MIN,    63'd1,  1'b0, 64'd0},
        '{S64_MAX,    MAX63,  1'b0, 64'd0},
        '{S64_MIN,    MAX63,  1'b0, 64'd0},
        '{Q_ONE,      63'(Q_ONE), 1'b0, 64'd0},
        '{-Q_ONE,     63'(Q_ONE), 1'b0, 64'd0},
        '{64'd1,      63'd1,  1'b0, 64'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 63'd2, 1'b0, 64'd0},
        '{64'h0000_0000_8000_0000, 63'h0000_0000_0100_0000, 1'b0, 64'd0}
    };

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        flow_rate = '0;
        time_step = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        hold_req = 0;
        res_r = 63'(Q_ONE);
        comp_c = 63'(Q_ONE);
        imp_z = '0;
        ord_code = 2'd1;
        pres_now = '0; pres_b1 = '0; pres_b2 = '0;
        flow_b1 = '0; flow_b2 = '0; flow_b3 = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_beat(rows[i].q, rows[i].dt, rows[i].typed, rows[i].want);
        drain_all();

        // receiver holds off for a long stretch while beats keep coming
        hold_req = 1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // settings change only with nothing in flight
            case (ph)
                0:
                begin   // top of every range, but initial pressure at its bottom
                    write_reg(CFG_RESISTANCE, {1'b0, MAX63});
                    write_reg(CFG_COMPLIANCE, {1'b0, MAX63});
                    write_reg(CFG_CHAR_IMP,   {1'b0, MAX63});
                    write_reg(CFG_BDF_ORDER,  64'd3);
                    write_reg(CFG_INIT_PRES,  S64_MIN);
                    write_reg(CFG_INIT_FLOW,  S64_MAX);
                end
                1:
                begin   // bottom of every range, but initial pressure at its top
                    write_reg(CFG_RESISTANCE, 64'd1);
                    write_reg(CFG_COMPLIANCE, 64'd1);
                    write_reg(CFG_CHAR_IMP,   64'd0);
                    write_reg(CFG_BDF_ORDER,  64'd0);
                    write_reg(CFG_INIT_PRES,  S64_MAX);
                    write_reg(CFG_INIT_FLOW,  S64_MIN);
                end
                default:
                begin
                    write_reg(CFG_RESISTANCE, {$urandom, $urandom} & ~S64_MIN);
                    write_reg(CFG_RESISTANCE, {1'b0, pick_coef()});
                    write_reg(CFG_COMPLIANCE, {1'b0, pick_coef()});
                    write_reg(CFG_CHAR_IMP,
                              ($urandom_range(0, 3) == 0) ? 64'd0 : {1'b0, pick_coef()});
                    write_reg(CFG_BDF_ORDER, {$urandom, $urandom});
                    write_reg(CFG_INIT_PRES, ($urandom_range(0, 1) != 0) ? rand_q()
                                             : {$urandom, $urandom});
                    write_reg(CFG_INIT_FLOW, ($urandom_range(0, 1) != 0) ? rand_q()
                                             : {$urandom, $urandom});
                end
            endcase
            // unmapped indexes must leave everything alone
            write_reg(3'($urandom_range(6, 7)), {$urandom, $urandom});

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_beat({$urandom, $urandom}, 63'({$urandom, $urandom}) | 63'd1,
                              1'b0, 64'd0);
                else
                    send_beat(rand_q(), rand_dt(), 1'b0, 64'd0);
            end
            drain_all();
        end

        repeat (DRAIN_WAIT) @(negedge clk);
        if (error_count == 0 && pending_pressure.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
